// ===== rtl/bma_pkg.sv =====
`default_nettype none
package bma_pkg;

   // Default sizes of the pool and of each free list.
   localparam int MAX_ORDER_DEF  = 10;
   localparam int LIST_DEPTH_DEF = 512;

   // Width of an order value and the mark for an address that starts no allocated block.
   localparam int ORD_W = 5;
   localparam logic [ORD_W-1:0] NOT_ALLOC = 5'd31;

   // Width used for pool size comparisons (pool sizes up to 2^16).
   localparam int POOL_W = 17;

   // Result status codes.
   localparam logic [2:0] STAT_ALLOC   = 3'd0;
   localparam logic [2:0] STAT_NOSPACE = 3'd1;
   localparam logic [2:0] STAT_FREED   = 3'd2;
   localparam logic [2:0] STAT_MERGED  = 3'd3;
   localparam logic [2:0] STAT_INVALID = 3'd4;

   // Operation codes of a request.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Commands from the controller to the datapath.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLR_STEP,
      CMD_LOAD,
      CMD_FAIL,
      CMD_INVALID,
      CMD_SEARCH_INIT,
      CMD_I_INC,
      CMD_TBL_READ,
      CMD_HEAD_READ,
      CMD_POP_TAKE,
      CMD_SHIFT_RD,
      CMD_SHIFT_WR,
      CMD_SHIFT_END,
      CMD_SPLIT,
      CMD_ALLOC_DONE,
      CMD_FREE_START,
      CMD_SCAN_INIT,
      CMD_SCAN_RD,
      CMD_SCAN_INC,
      CMD_MERGE_TAKE,
      CMD_MERGE_UP
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic cfg_wr;
      logic clr_last;
      logic op_free;
      logic req_bad;
      logic addr_oob;
      logic i_over;
      logic cnt_nz;
      logic i_gt_x;
      logic tbl_na;
      logic n_lt_top;
      logic scan_end;
      logic scan_hit;
      logic shift_done;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/bma_req_if.sv =====
`default_nettype none
interface bma_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [10:0] request_size;
   logic [9:0]  block_address;

   modport source (output valid, output op, output request_size, output block_address,
                   input ready);
   modport sink (input valid, input op, input request_size, input block_address,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/bma_rsp_if.sv =====
`default_nettype none
interface bma_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [9:0]  address;
   logic [10:0] block_size;

   modport source (output valid, output status, output address, output block_size,
                   input ready);
   modport sink (input valid, input status, input address, input block_size,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/bma_ram.sv =====
`default_nettype none
module bma_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/bma_ctrl.sv =====
`default_nettype none
module bma_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          rsp_ready,
   input  wire bma_pkg::stat_type st,
   output bma_pkg::ctl_type   ctl,
   output logic               req_ready,
   output logic               rsp_valid
);
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_SEARCH,
      S_POP_WAIT,
      S_SHIFT,
      S_SHIFT_WR,
      S_SPLIT,
      S_FREE_CHK,
      S_MERGE_CHK,
      S_SCAN,
      S_SCAN_CMP,
      S_MERGE_UP,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // Next state and the command for this cycle.
   always_comb begin
      state_in = state_ff;
      ctl.cmd  = bma_pkg::CMD_NONE;
      case (state_ff)
         S_CLEAR: begin
            ctl.cmd = bma_pkg::CMD_CLR_STEP;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.cmd  = bma_pkg::CMD_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!st.op_free) begin
               if (st.req_bad) begin
                  ctl.cmd  = bma_pkg::CMD_FAIL;
                  state_in = S_RESP;
               end else begin
                  ctl.cmd  = bma_pkg::CMD_SEARCH_INIT;
                  state_in = S_SEARCH;
               end
            end else if (st.addr_oob) begin
               ctl.cmd  = bma_pkg::CMD_INVALID;
               state_in = S_RESP;
            end else begin
               ctl.cmd  = bma_pkg::CMD_TBL_READ;
               state_in = S_FREE_CHK;
            end
         end
         S_SEARCH: begin
            if (st.i_over) begin
               ctl.cmd  = bma_pkg::CMD_FAIL;
               state_in = S_RESP;
            end else if (st.cnt_nz) begin
               ctl.cmd  = bma_pkg::CMD_HEAD_READ;
               state_in = S_POP_WAIT;
            end else begin
               ctl.cmd = bma_pkg::CMD_I_INC;
            end
         end
         S_POP_WAIT: begin
            ctl.cmd  = bma_pkg::CMD_POP_TAKE;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (st.shift_done) begin
               ctl.cmd  = bma_pkg::CMD_SHIFT_END;
               state_in = st.op_free ? S_MERGE_UP : S_SPLIT;
            end else begin
               ctl.cmd  = bma_pkg::CMD_SHIFT_RD;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ctl.cmd  = bma_pkg::CMD_SHIFT_WR;
            state_in = S_SHIFT;
         end
         S_SPLIT: begin
            if (st.i_gt_x) begin
               ctl.cmd = bma_pkg::CMD_SPLIT;
            end else begin
               ctl.cmd  = bma_pkg::CMD_ALLOC_DONE;
               state_in = S_RESP;
            end
         end
         S_FREE_CHK: begin
            if (st.tbl_na) begin
               ctl.cmd  = bma_pkg::CMD_INVALID;
               state_in = S_RESP;
            end else begin
               ctl.cmd  = bma_pkg::CMD_FREE_START;
               state_in = S_MERGE_CHK;
            end
         end
         S_MERGE_CHK: begin
            if (st.n_lt_top) begin
               ctl.cmd  = bma_pkg::CMD_SCAN_INIT;
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (st.scan_end) begin
               state_in = S_RESP;
            end else begin
               ctl.cmd  = bma_pkg::CMD_SCAN_RD;
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (st.scan_hit) begin
               ctl.cmd  = bma_pkg::CMD_MERGE_TAKE;
               state_in = S_SHIFT;
            end else begin
               ctl.cmd  = bma_pkg::CMD_SCAN_INC;
               state_in = S_SCAN;
            end
         end
         S_MERGE_UP: begin
            ctl.cmd  = bma_pkg::CMD_MERGE_UP;
            state_in = S_MERGE_CHK;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // A register write restarts the table clearing pass.
      if (st.cfg_wr) state_in = S_CLEAR;
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= (state_in == S_RESP);
      end
   end

   // One request at a time: never ready while a result waits.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("request ready while a result is pending");

   // An accepted request closes the input until its result is taken.
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready_ff) |=> !req_ready_ff)
      else $error("still ready after accepting a request");

   // A register write starts a clearing pass that blocks requests.
   a_cfg_clear: assert property (@(posedge clock) disable iff (reset)
      st.cfg_wr |=> (!req_ready_ff && !rsp_valid_ff))
      else $error("request channel open right after a register write");
endmodule
`default_nettype wire

// ===== rtl/bma_dpath.sv =====
`default_nettype none
module bma_dpath #(
   parameter int MAX_ORDER  = bma_pkg::MAX_ORDER_DEF,
   parameter int LIST_DEPTH = bma_pkg::LIST_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bma_pkg::ctl_type             ctl,
   output bma_pkg::stat_type                 st,
   input  wire logic                         cfg_we,
   input  wire logic [3:0]                   cfg_data,
   output logic      [bma_pkg::ORD_W-1:0]    total_order,
   input  wire logic                         in_op,
   input  wire logic [10:0]                  in_request_size,
   input  wire logic [9:0]                   in_block_address,
   output logic      [2:0]                   out_status,
   output logic      [9:0]                   out_address,
   output logic      [10:0]                  out_block_size
);
   localparam int OW       = bma_pkg::ORD_W;
   localparam int NORD     = MAX_ORDER + 1;
   localparam int OIW      = $clog2(NORD);
   localparam int AW       = MAX_ORDER;
   localparam int CW       = $clog2(LIST_DEPTH + 1);
   localparam int FL_DEPTH = NORD * LIST_DEPTH;
   localparam int FW       = $clog2(FL_DEPTH);
   localparam int TD       = 1 << MAX_ORDER;
   localparam int PLW      = bma_pkg::POOL_W;
   localparam logic [OW-1:0] MAXO     = OW'(MAX_ORDER);
   localparam logic [OW-1:0] TORD_RST = OW'(MAX_ORDER < 10 ? MAX_ORDER : 10);
   localparam logic [CW-1:0] DEPTH_C  = CW'(LIST_DEPTH);
   localparam logic [CW-1:0] SPLIT_C  = LIST_DEPTH >= 2 ? CW'(1) : CW'(0);

   // Architectural state.
   logic [OW-1:0] tord_ff, tord_in;
   logic [CW-1:0] cnt_ff [NORD];
   logic [CW-1:0] cnt_in [NORD];
   logic [AW-1:0] clr_ff, clr_in;

   // Per-request working registers.
   logic          op_ff, op_in;
   logic [10:0]   req_ff, req_in;
   logic [9:0]    baddr_ff, baddr_in;
   logic [OW-1:0] x_ff, x_in;
   logic [OW-1:0] i_ff, i_in;
   logic [AW-1:0] a_ff, a_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          dec_ff, dec_in;
   logic [2:0]    status_ff, status_in;
   logic [9:0]    addr_ff, addr_in;
   logic [10:0]   bsize_ff, bsize_in;

   // Memory ports.
   logic          fl_we, fl_re;
   logic [FW-1:0] fl_waddr, fl_raddr;
   logic [AW-1:0] fl_wdata, fl_rdata;
   logic          tbl_we, tbl_re;
   logic [AW-1:0] tbl_waddr, tbl_raddr;
   logic [OW-1:0] tbl_wdata, tbl_rdata;

   // Derived values.
   logic [PLW-1:0] pool;
   logic [10:0]    req_m1;
   logic [OW-1:0]  x_calc;
   logic [OIW-1:0] oi;
   logic [CW-1:0]  cur_cnt;
   logic [AW-1:0]  buddy;
   logic [CW:0]    pos_p1;
   logic           push_en;
   logic [OIW-1:0] push_ord;
   logic [AW-1:0]  push_val;

   function automatic logic [FW-1:0] fl_addr(input logic [OIW-1:0] ord,
                                             input logic [CW-1:0] pos);
      return FW'(ord) * FW'(LIST_DEPTH) + FW'(pos);
   endfunction

   assign total_order = tord_ff;

   bma_ram #(.WIDTH(AW), .DEPTH(FL_DEPTH)) u_fl_ram (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_waddr),
      .wr_data (fl_wdata),
      .rd_en   (fl_re),
      .rd_addr (fl_raddr),
      .rd_data (fl_rdata)
   );

   bma_ram #(.WIDTH(OW), .DEPTH(TD)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   // Rounded-up order of the request: bit length of size minus one.
   always_comb begin
      req_m1 = req_ff - 11'd1;
      x_calc = '0;
      for (int b = 0; b < 11; b++) begin
         if (req_m1[b]) x_calc = OW'(b + 1);
      end
   end

   // Status toward the controller.
   assign pool    = PLW'(1) << tord_ff;
   assign oi      = i_ff[OIW-1:0];
   assign cur_cnt = (i_ff <= MAXO) ? cnt_ff[oi] : '0;
   assign buddy   = a_ff ^ (AW'(1) << i_ff);
   assign pos_p1  = {1'b0, pos_ff} + (CW+1)'(1);

   always_comb begin
      st.cfg_wr     = cfg_we;
      st.clr_last   = &clr_ff;
      st.op_free    = (op_ff == bma_pkg::OP_FREE);
      st.req_bad    = (req_ff == 11'd0) || (PLW'(req_ff) > pool);
      st.addr_oob   = PLW'(baddr_ff) >= pool;
      st.i_over     = i_ff > tord_ff;
      st.cnt_nz     = cur_cnt != '0;
      st.i_gt_x     = i_ff > x_ff;
      st.tbl_na     = tbl_rdata == bma_pkg::NOT_ALLOC;
      st.n_lt_top   = i_ff < tord_ff;
      st.scan_end   = pos_ff >= cur_cnt;
      st.scan_hit   = (fl_rdata == buddy) && (pos_p1 != {1'b0, cur_cnt});
      st.shift_done = pos_p1 >= {1'b0, cur_cnt};
   end

   // Command execution.
   always_comb begin
      tord_in   = tord_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      req_in    = req_ff;
      baddr_in  = baddr_ff;
      x_in      = x_ff;
      i_in      = i_ff;
      a_in      = a_ff;
      pos_in    = pos_ff;
      dec_in    = dec_ff;
      status_in = status_ff;
      addr_in   = addr_ff;
      bsize_in  = bsize_ff;
      fl_we     = 1'b0;
      fl_re     = 1'b0;
      fl_waddr  = '0;
      fl_raddr  = '0;
      fl_wdata  = '0;
      tbl_we    = 1'b0;
      tbl_re    = 1'b0;
      tbl_waddr = '0;
      tbl_raddr = '0;
      tbl_wdata = '0;
      push_en   = 1'b0;
      push_ord  = '0;
      push_val  = '0;
      case (ctl.cmd)
         bma_pkg::CMD_CLR_STEP: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            tbl_wdata = bma_pkg::NOT_ALLOC;
            clr_in    = clr_ff + AW'(1);
            fl_we     = 1'b1;
            fl_waddr  = fl_addr(tord_ff[OIW-1:0], '0);
         end
         bma_pkg::CMD_LOAD: begin
            op_in    = in_op;
            req_in   = in_request_size;
            baddr_in = in_block_address;
         end
         bma_pkg::CMD_FAIL: begin
            status_in = bma_pkg::STAT_NOSPACE;
            addr_in   = '0;
            bsize_in  = '0;
         end
         bma_pkg::CMD_INVALID: begin
            status_in = bma_pkg::STAT_INVALID;
            addr_in   = baddr_ff;
            bsize_in  = '0;
         end
         bma_pkg::CMD_SEARCH_INIT: begin
            x_in = x_calc;
            i_in = x_calc;
         end
         bma_pkg::CMD_I_INC: begin
            i_in = i_ff + OW'(1);
         end
         bma_pkg::CMD_TBL_READ: begin
            tbl_re    = 1'b1;
            tbl_raddr = AW'(baddr_ff);
         end
         bma_pkg::CMD_HEAD_READ: begin
            fl_re    = 1'b1;
            fl_raddr = fl_addr(oi, '0);
         end
         bma_pkg::CMD_POP_TAKE: begin
            a_in   = fl_rdata;
            pos_in = '0;
            dec_in = 1'b0;
         end
         bma_pkg::CMD_SHIFT_RD: begin
            fl_re    = 1'b1;
            fl_raddr = fl_addr(oi, pos_p1[CW-1:0]);
         end
         bma_pkg::CMD_SHIFT_WR: begin
            fl_we    = 1'b1;
            fl_waddr = fl_addr(oi, pos_ff);
            fl_wdata = fl_rdata;
            pos_in   = pos_ff + CW'(1);
         end
         bma_pkg::CMD_SHIFT_END: begin
            cnt_in[oi] = cnt_ff[oi] - (dec_ff ? CW'(2) : CW'(1));
         end
         bma_pkg::CMD_SPLIT: begin
            // The lower level is empty here, so the lower half is taken at once
            // and only the upper half stays listed.
            i_in     = i_ff - OW'(1);
            fl_we    = 1'b1;
            fl_waddr = fl_addr(oi - OIW'(1), '0);
            fl_wdata = a_ff + (AW'(1) << i_in);
            cnt_in[oi - OIW'(1)] = SPLIT_C;
         end
         bma_pkg::CMD_ALLOC_DONE: begin
            tbl_we    = 1'b1;
            tbl_waddr = a_ff;
            tbl_wdata = x_ff;
            status_in = bma_pkg::STAT_ALLOC;
            addr_in   = 10'(a_ff);
            bsize_in  = 11'(PLW'(1) << x_ff);
         end
         bma_pkg::CMD_FREE_START: begin
            i_in      = tbl_rdata;
            a_in      = AW'(baddr_ff);
            tbl_we    = 1'b1;
            tbl_waddr = AW'(baddr_ff);
            tbl_wdata = bma_pkg::NOT_ALLOC;
            status_in = bma_pkg::STAT_FREED;
            addr_in   = baddr_ff;
            bsize_in  = 11'(PLW'(1) << tbl_rdata);
            push_en   = 1'b1;
            push_ord  = tbl_rdata[OIW-1:0];
            push_val  = AW'(baddr_ff);
         end
         bma_pkg::CMD_SCAN_INIT: begin
            pos_in = '0;
         end
         bma_pkg::CMD_SCAN_RD: begin
            fl_re    = 1'b1;
            fl_raddr = fl_addr(oi, pos_ff);
         end
         bma_pkg::CMD_SCAN_INC: begin
            pos_in = pos_ff + CW'(1);
         end
         bma_pkg::CMD_MERGE_TAKE: begin
            // Remove the buddy in place, then drop the just-freed block at the tail.
            dec_in = 1'b1;
         end
         bma_pkg::CMD_MERGE_UP: begin
            a_in      = (a_ff < buddy) ? a_ff : buddy;
            i_in      = i_ff + OW'(1);
            status_in = bma_pkg::STAT_MERGED;
            push_en   = 1'b1;
            push_ord  = oi + OIW'(1);
            push_val  = (a_ff < buddy) ? a_ff : buddy;
         end
         default: begin
         end
      endcase

      // Append to a free list unless it is full.
      if (push_en && (cnt_ff[push_ord] < DEPTH_C)) begin
         fl_we            = 1'b1;
         fl_waddr         = fl_addr(push_ord, cnt_ff[push_ord]);
         fl_wdata         = push_val;
         cnt_in[push_ord] = cnt_ff[push_ord] + CW'(1);
      end

      // A register write leaves one whole block at the new top order.
      if (cfg_we) begin
         tord_in = (OW'(cfg_data) > MAXO) ? MAXO : OW'(cfg_data);
         for (int k = 0; k < NORD; k++) begin
            cnt_in[k] = '0;
         end
         cnt_in[tord_in[OIW-1:0]] = CW'(1);
         clr_in = '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tord_ff <= TORD_RST;
         clr_ff  <= '0;
         for (int k = 0; k < NORD; k++) begin
            cnt_ff[k] <= (k == int'(TORD_RST)) ? CW'(1) : CW'(0);
         end
      end else begin
         tord_ff <= tord_in;
         clr_ff  <= clr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      req_ff    <= req_in;
      baddr_ff  <= baddr_in;
      x_ff      <= x_in;
      i_ff      <= i_in;
      a_ff      <= a_in;
      pos_ff    <= pos_in;
      dec_ff    <= dec_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      bsize_ff  <= bsize_in;
   end

   assign out_status     = status_ff;
   assign out_address    = addr_ff;
   assign out_block_size = bsize_ff;
endmodule
`default_nettype wire

// ===== rtl/buddy_memory_allocator_top.sv =====
`default_nettype none
// Buddy allocator, one request at a time; the next request is taken after the result.
// A granted allocate searches upward past each empty order, then moves up the entries
// of the list that it takes from, and then splits one level at a time down to the size.
// Free: at the top order no list is scanned; at each lower level it scans list entries
// and then stops when no buddy is found, or moves entries up and merges when it finds one.
// Reset and every total_order write start a table clearing pass; no request is taken.
module buddy_memory_allocator_top #(
   parameter int MAX_ORDER  = bma_pkg::MAX_ORDER_DEF,
   parameter int LIST_DEPTH = bma_pkg::LIST_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bma_req_if.sink          req_ch,
   bma_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   bma_pkg::ctl_type               ctl;
   bma_pkg::stat_type              st;
   logic                           cfg_we;
   logic [bma_pkg::ORD_W-1:0]      tord;

   // Register decode: total_order is the only register, at byte addresses zero to three.
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(tord);

   bma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .ctl       (ctl),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid)
   );

   bma_dpath #(.MAX_ORDER(MAX_ORDER), .LIST_DEPTH(LIST_DEPTH)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .st               (st),
      .cfg_we           (cfg_we),
      .cfg_data         (csr_pwdata[3:0]),
      .total_order      (tord),
      .in_op            (req_ch.op),
      .in_request_size  (req_ch.request_size),
      .in_block_address (req_ch.block_address),
      .out_status       (rsp_ch.status),
      .out_address      (rsp_ch.address),
      .out_block_size   (rsp_ch.block_size)
   );
endmodule
`default_nettype wire

// ===== sim/buddy_memory_allocator_checker.sv =====
`default_nettype none
module buddy_memory_allocator_checker #(
   parameter int MAX_ORDER  = bma_pkg::MAX_ORDER_DEF,
   parameter int LIST_DEPTH = bma_pkg::LIST_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bma_req_if               req,
   bma_rsp_if               rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               failures,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_TOTAL_ORDER = 3'd0;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  address;
      logic [10:0] block_size;
   } grant_type;

   // Shadow copy of the allocator state.
   logic [9:0]                pool_lists [MAX_ORDER+1][LIST_DEPTH];
   int                        pool_counts [MAX_ORDER+1];
   logic [bma_pkg::ORD_W-1:0] owner_order [1 << MAX_ORDER];
   int                        pool_order;
   grant_type                 pending_grants [$];

   // Empties every list and leaves the whole pool as one free block.
   function automatic void clear_pool(int ord);
      pool_order = ord;
      for (int o = 0; o <= MAX_ORDER; o++) pool_counts[o] = 0;
      for (int a = 0; a < (1 << MAX_ORDER); a++) owner_order[a] = bma_pkg::NOT_ALLOC;
      pool_lists[ord][0] = '0;
      pool_counts[ord] = 1;
   endfunction

   function automatic void list_append(int o, logic [9:0] a);
      if (pool_counts[o] < LIST_DEPTH) begin
         pool_lists[o][pool_counts[o]] = a;
         pool_counts[o]++;
      end
   endfunction

   function automatic void list_drop(int o, int pos);
      if (pos >= pool_counts[o]) return;
      for (int j = pos; j < pool_counts[o] - 1; j++) pool_lists[o][j] = pool_lists[o][j+1];
      pool_counts[o]--;
   endfunction

   function automatic logic [9:0] list_take(int o);
      logic [9:0] a;
      a = pool_lists[o][0];
      list_drop(o, 0);
      return a;
   endfunction

   // Works out the response to one request and updates the shadow state.
   function automatic grant_type allocate_or_free(logic op, logic [10:0] size,
                                                  logic [9:0] baddr);
      grant_type  g;
      int         pool, x, i, n;
      logic [9:0] a, buddy;
      bit         merging;
      pool = 1 << pool_order;
      g = '0;
      if (op == bma_pkg::OP_ALLOC) begin
         g.status = bma_pkg::STAT_NOSPACE;
         if (size != 0 && size <= pool) begin
            x = 0;
            while ((1 << x) < size) x++;
            for (i = x; i <= pool_order; i++) if (pool_counts[i] != 0) break;
            if (i <= pool_order) begin
               a = list_take(i);
               while (i > x) begin
                  i--;
                  list_append(i, a);
                  list_append(i, a + 10'(1 << i));
                  a = list_take(i);
               end
               owner_order[a] = bma_pkg::ORD_W'(x);
               g.status = bma_pkg::STAT_ALLOC;
               g.address = a;
               g.block_size = 11'(1 << x);
            end
         end
      end else begin
         g.address = baddr;
         if (baddr >= pool || owner_order[baddr] == bma_pkg::NOT_ALLOC) begin
            g.status = bma_pkg::STAT_INVALID;
         end else begin
            n = owner_order[baddr];
            a = baddr;
            merging = 1;
            owner_order[baddr] = bma_pkg::NOT_ALLOC;
            g.block_size = 11'(1 << n);
            g.status = bma_pkg::STAT_FREED;
            list_append(n, a);
            // Coalesce upward while the buddy sits in the list ahead of the tail.
            while (merging && n < pool_order) begin
               buddy = a ^ 10'(1 << n);
               merging = 0;
               for (int k = 0; k < pool_counts[n]; k++) begin
                  if (pool_lists[n][k] == buddy && k + 1 != pool_counts[n]) begin
                     list_drop(n, k);
                     list_drop(n, pool_counts[n] - 1);
                     if (buddy < a) a = buddy;
                     n++;
                     list_append(n, a);
                     g.status = bma_pkg::STAT_MERGED;
                     merging = 1;
                     break;
                  end
               end
            end
         end
      end
      return g;
   endfunction

   task automatic report_mismatch(string what, logic [10:0] got, logic [10:0] want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      failures++;
   endtask

   assign outstanding = pending_grants.size();

   initial begin
      failures = 0;
      clear_pool(MAX_ORDER < 10 ? MAX_ORDER : 10);
   end

   // Watch the channels and the register port at each rising edge.
   always @(posedge clock) begin
      grant_type want;
      int        v;
      if (reset) begin
         clear_pool(MAX_ORDER < 10 ? MAX_ORDER : 10);
         pending_grants.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ADDR_TOTAL_ORDER) begin
            v = csr_pwdata[3:0];
            clear_pool(v > MAX_ORDER ? MAX_ORDER : v);
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_grants.size() == 0) begin
               $display("%0t: response with no request waiting", $realtime);
               failures++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", 11'(rsp.status), 11'(want.status));
               if (rsp.address !== want.address)
                  report_mismatch("address", 11'(rsp.address), 11'(want.address));
               if (rsp.block_size !== want.block_size)
                  report_mismatch("block_size", rsp.block_size, want.block_size);
            end
         end
         if (req.valid && req.ready)
            pending_grants = {pending_grants, allocate_or_free(req.op, req.request_size,
                                                               req.block_address)};
      end
   end
endmodule
`default_nettype wire

// ===== sim/buddy_memory_allocator_top_tb.sv =====
`default_nettype none
module buddy_memory_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_TOTAL_ORDER = 3'd0;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          failures;
   int          outstanding;

   bma_req_if req_ch ();
   bma_rsp_if rsp_ch ();

   buddy_memory_allocator_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   buddy_memory_allocator_checker u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .failures(failures), .outstanding(outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   bit         hold_request = 0;
   bit         hold_done = 0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   int         cur_order = 10;
   logic [9:0] live_blocks [$];

   // Response side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_request && !hold_done) begin
            hold_done = 1;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Track granted blocks so that most frees hit a live block.
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == bma_pkg::STAT_ALLOC)
         live_blocks = {live_blocks, rsp_ch.address};
      if (csr_psel && csr_penable && csr_pwrite) live_blocks.delete();
   end

   // Ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic op, logic [10:0] size, logic [9:0] baddr);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.request_size <= size;
      req_ch.block_address <= baddr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_total_order(int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_TOTAL_ORDER;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_order = value > 10 ? 10 : value;
   endtask

   // One random request: mostly small allocations and frees of live blocks.
   task automatic random_request();
      int         pick, ord, hi;
      logic [9:0] baddr;
      pick = $urandom_range(99);
      if (pick < 50) begin
         ord = $urandom_range(0, $urandom_range(0, cur_order));
         hi = 1 << ord;
         send_request(bma_pkg::OP_ALLOC, 11'($urandom_range(hi / 2 + 1, hi)),
                      10'($urandom));
      end else if (pick < 88 && live_blocks.size() != 0) begin
         ord = $urandom_range(0, live_blocks.size() - 1);
         baddr = live_blocks[ord];
         live_blocks.delete(ord);
         send_request(bma_pkg::OP_FREE, 11'($urandom), baddr);
      end else if (pick < 94) begin
         send_request(bma_pkg::OP_FREE, 11'($urandom), 10'($urandom));
      end else begin
         send_request(1'($urandom), 11'($urandom), 10'($urandom));
      end
   endtask

   initial begin
      int orders [6] = '{10, 0, 3, 15, 5, 10};
      int stalls [4] = '{0, 0, 66, 31};
      int idles [4]  = '{0, 66, 0, 31};
      req_ch.valid <= 1'b0;
      req_ch.op <= bma_pkg::OP_ALLOC;
      req_ch.request_size <= '0;
      req_ch.block_address <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: pool extremes, invalid frees, merges.
      send_request(bma_pkg::OP_ALLOC, 11'd0, 10'd0);
      send_request(bma_pkg::OP_ALLOC, 11'd1024, 10'd0);
      send_request(bma_pkg::OP_ALLOC, 11'd1, 10'd0);
      send_request(bma_pkg::OP_FREE, 11'd0, 10'd0);
      send_request(bma_pkg::OP_FREE, 11'd0, 10'd0);
      send_request(bma_pkg::OP_ALLOC, 11'd1025, 10'h3FF);
      send_request(bma_pkg::OP_ALLOC, 11'h7FF, 10'h3FF);
      send_request(bma_pkg::OP_FREE, 11'h7FF, 10'h3FF);
      send_request(bma_pkg::OP_ALLOC, 11'd1, 10'd0);
      send_request(bma_pkg::OP_ALLOC, 11'd1, 10'd0);
      send_request(bma_pkg::OP_ALLOC, 11'd3, 10'd0);
      send_request(bma_pkg::OP_ALLOC, 11'd513, 10'd0);
      send_request(bma_pkg::OP_FREE, 11'd0, 10'd0);
      send_request(bma_pkg::OP_FREE, 11'd0, 10'd1);
      send_request(bma_pkg::OP_FREE, 11'd0, 10'd4);
      send_request(bma_pkg::OP_ALLOC, 11'd512, 10'd0);
      send_request(bma_pkg::OP_ALLOC, 11'd512, 10'd0);
      send_request(bma_pkg::OP_FREE, 11'd0, 10'd512);
      send_request(bma_pkg::OP_FREE, 11'd0, 10'd0);
      drain_responses();

      // Random phases over several pool sizes and idling patterns.
      for (int p = 0; p < 6; p++) begin
         write_total_order(orders[p]);
         send_request(bma_pkg::OP_ALLOC, 11'(1 << cur_order), 10'd0);
         send_request(bma_pkg::OP_ALLOC, 11'((1 << cur_order) + 1), 10'd0);
         send_request(bma_pkg::OP_FREE, 11'd0, 10'd0);
         for (int k = 0; k < 185; k++) begin
            sender_idle_pct = idles[(k / 30 + p) % 4];
            receiver_stall_pct = stalls[(k / 30 + p) % 4];
            if (p == 0 && k == 60) hold_request = 1;
            random_request();
         end
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
         drain_responses();
      end

      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
